### hdl/pal_pkg.sv
package pal_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned STAT_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic             REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_GET    = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK            = 3'd0,
    ST_NULL          = 3'd1,
    ST_BEYOND_CAP    = 3'd2,
    ST_FULL          = 3'd3,
    ST_NOT_BELOW_LEN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_WAIT = 2'd2
  } fsm_e;

  typedef struct packed {
    cell_op_e         op;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

### hdl/pal_cell.sv
module pal_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                       clk_i,
  input  pal_pkg::cell_ctrl_t        ctrl_i,
  input  logic [pal_pkg::DATA_W-1:0] item_i,
  input  logic [pal_pkg::DATA_W-1:0] left_i,
  input  logic [pal_pkg::DATA_W-1:0] right_i,
  output logic [pal_pkg::DATA_W-1:0] word_o,
  output logic [pal_pkg::DATA_W-1:0] rd_o
);

  localparam logic [31:0] Idx = 32'(IDX);

  logic [pal_pkg::DATA_W-1:0] word_q;
  logic [pal_pkg::DATA_W-1:0] word_d;
  logic [31:0]                pos_x;

  assign pos_x = 32'(ctrl_i.pos);

  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      pal_pkg::OP_INSERT: begin
        if (Idx > pos_x) begin
          word_d = left_i;
        end else if (Idx == pos_x) begin
          word_d = item_i;
        end
      end
      pal_pkg::OP_DELETE: begin
        if (Idx >= pos_x) begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign rd_o   = (Idx == pos_x) ? word_q : '0;

endmodule

### hdl/pal_or_tree.sv
module pal_or_tree #(
  parameter int unsigned N = 64,
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] leaf_i [N],
  output logic [W-1:0] root_o
);

  localparam int unsigned LV = $clog2(N);
  localparam int unsigned P  = 1 << LV;

  logic [W-1:0] node_q [P-1];

  for (genvar i = 0; i < P - 1; i++) begin : g_node
    localparam int unsigned L = 2 * i + 1;
    localparam int unsigned R = 2 * i + 2;
    logic [W-1:0] lc;
    logic [W-1:0] rc;

    if (L >= P - 1) begin : g_lleaf
      if (L - (P - 1) < N) begin : g_in
        assign lc = leaf_i[L-(P-1)];
      end else begin : g_pad
        assign lc = '0;
      end
    end else begin : g_lnode
      assign lc = node_q[L];
    end

    if (R >= P - 1) begin : g_rleaf
      if (R - (P - 1) < N) begin : g_in
        assign rc = leaf_i[R-(P-1)];
      end else begin : g_pad
        assign rc = '0;
      end
    end else begin : g_rnode
      assign rc = node_q[R];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        node_q[i] <= lc | rc;
      end
    end
  end

  assign root_o = node_q[0];

endmodule

### hdl/positional_array_list_top.sv
// Ordered list of 32-bit words held in a row of DEPTH cells. Insert shifts the
// tail up, delete shifts it down, both at once across the whole row; get and
// delete read the addressed word back through a registered OR tree of
// clog2(DEPTH) levels. One request is in flight at a time: a new request is
// taken only after the tree has settled and the result has been loaded into
// the output register. A finished result waits there without blocking the
// acceptance of the next request, though that request's result is held until
// the register frees. No clearing pass runs after reset; capacity_limit sits
// at byte address 0 of the configuration port and resets to 64.
module positional_array_list_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // position[5:0], item_value[37:6], zero[39:38]
  input  logic [39:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[31:0], list_length[38:32], zero[39]
  output logic [39:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned XW    = (CW > pal_pkg::CAP_W) ? CW : pal_pkg::CAP_W;
  localparam int unsigned LV    = $clog2(DEPTH);
  localparam int unsigned CNT_W = (LV > 1) ? $clog2(LV) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(LV - 1);
  localparam int unsigned DW    = pal_pkg::DATA_W;

  pal_pkg::fsm_e              state_q, state_d;
  pal_pkg::req_e              req_q;
  logic [pal_pkg::POS_W-1:0]  pos_q;
  logic [DW-1:0]              item_q;
  logic [CW-1:0]              count_q, count_n;
  logic [pal_pkg::CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]           cnt_q;
  pal_pkg::status_e           stat_q, stat_c;
  logic [pal_pkg::LEN_W-1:0]  len_q;
  logic                       rdok_q, rdok_c;
  logic                       out_valid_q;
  logic [39:0]                out_data_q;
  logic [2:0]                 out_user_q;

  logic                       in_acc, out_free, load_out, tree_en, exec;
  logic [XW-1:0]              cap_x, eff_cap, pos_x, cnt_x, len_x;
  logic [pal_pkg::POS_W-1:0]  cell_pos;
  pal_pkg::cell_op_e          op_c;
  pal_pkg::cell_ctrl_t        cell_ctrl;
  logic [DW-1:0]              word [DEPTH];
  logic [DW-1:0]              rd [DEPTH];
  logic [DW-1:0]              root;
  logic                       cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == pal_pkg::REG_CAPACITY) ? {25'b0, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= pal_pkg::CAP_RESET;
    end else if (cfg_wr && paddr[2] == pal_pkg::REG_CAPACITY) begin
      cap_q <= pwdata[pal_pkg::CAP_W-1:0];
    end
  end

  // request decode
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign cap_x   = XW'(cap_q);
  assign eff_cap = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
  assign pos_x   = XW'(pos_q);
  assign cnt_x   = XW'(count_q);
  assign len_x   = XW'(count_n);

  always_comb begin
    stat_c   = pal_pkg::ST_OK;
    rdok_c   = 1'b0;
    op_c     = pal_pkg::OP_HOLD;
    cell_pos = pos_q;
    count_n  = count_q;
    case (req_q)
      pal_pkg::REQ_INSERT: begin
        if (item_q == '0) begin
          stat_c = pal_pkg::ST_NULL;
        end else if (pos_x >= eff_cap) begin
          stat_c = pal_pkg::ST_BEYOND_CAP;
        end else if (cnt_x >= eff_cap) begin
          stat_c = pal_pkg::ST_FULL;
        end else begin
          op_c    = pal_pkg::OP_INSERT;
          count_n = CW'(count_q + 1'b1);
          if (pos_x > cnt_x) begin
            cell_pos = cnt_x[pal_pkg::POS_W-1:0];
          end
        end
      end
      pal_pkg::REQ_GET, pal_pkg::REQ_DELETE: begin
        if (pos_x >= cnt_x) begin
          stat_c = pal_pkg::ST_NOT_BELOW_LEN;
        end else begin
          rdok_c = 1'b1;
          if (req_q == pal_pkg::REQ_DELETE) begin
            op_c    = pal_pkg::OP_DELETE;
            count_n = CW'(count_q - 1'b1);
          end
        end
      end
      default: count_n = '0;
    endcase
  end

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      pal_pkg::S_IDLE: if (in_acc) state_d = pal_pkg::S_EXEC;
      pal_pkg::S_EXEC: state_d = pal_pkg::S_WAIT;
      pal_pkg::S_WAIT: if (cnt_q == LAST && out_free) state_d = pal_pkg::S_IDLE;
      default:         state_d = pal_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    exec          = 1'b0;
    tree_en       = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      pal_pkg::S_IDLE: s_axis_tready = 1'b1;
      pal_pkg::S_EXEC: begin
        exec    = 1'b1;
        tree_en = 1'b1;
      end
      pal_pkg::S_WAIT: begin
        tree_en  = (cnt_q != LAST);
        load_out = (cnt_q == LAST) && out_free;
      end
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pal_pkg::S_IDLE;
      count_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec) begin
        count_q <= count_n;
        cnt_q   <= '0;
      end else if (state_q == pal_pkg::S_WAIT && cnt_q != LAST) begin
        cnt_q <= CNT_W'(cnt_q + 1'b1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= pal_pkg::req_e'(s_axis_tuser);
      pos_q  <= s_axis_tdata[5:0];
      item_q <= s_axis_tdata[37:6];
    end
    if (exec) begin
      stat_q <= stat_c;
      rdok_q <= rdok_c;
      len_q  <= len_x[pal_pkg::LEN_W-1:0];
    end
    if (load_out) begin
      out_data_q <= {1'b0, len_q, rdok_q ? root : {DW{1'b0}}};
      out_user_q <= stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // cell row
  assign cell_ctrl.op  = exec ? op_c : pal_pkg::OP_HOLD;
  assign cell_ctrl.pos = cell_pos;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DW-1:0] left_w;
    logic [DW-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = word[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = word[k];
    end else begin : g_mid_r
      assign right_w = word[k+1];
    end
    pal_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .item_i  (item_q),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (word[k]),
      .rd_o    (rd[k])
    );
  end

  pal_or_tree #(
    .N (DEPTH),
    .W (DW)
  ) u_tree (
    .clk_i  (clk_i),
    .en_i   (tree_en),
    .leaf_i (rd),
    .root_o (root)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list length beyond depth");

  a_load_at_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (state_q == pal_pkg::S_WAIT) && (cnt_q == LAST))
    else $error("result loaded before tree settled");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == pal_pkg::S_EXEC)
    else $error("accepted request not executed");

  a_clear_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && req_q == pal_pkg::REQ_CLEAR |=> count_q == '0)
    else $error("clear left entries");

  a_insert_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && op_c == pal_pkg::OP_INSERT |=> count_q == CW'($past(count_q) + 1'b1))
    else $error("insert did not grow list");

endmodule
